@@ src/wlhs_pkg.sv @@
// Shared types and constants for the waterfall line history store.
// Holds payload structs, controller/datapath command and status groups, codes.
// No dependencies.
package wlhs_pkg;

  localparam int MAX_BINS    = 1024;
  localparam int MAX_LINES   = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int ROW_W  = $clog2(MAX_LINES);
  localparam int CNT_W  = $clog2(MAX_BINS + 2);
  localparam int ADDR_W = $clog2(MAX_BINS * MAX_LINES);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINS_IN_USE  = 3'd0,
    CFG_LINES_IN_USE = 3'd1,
    CFG_X_ORIGIN     = 3'd2,
    CFG_X_SCALE      = 3'd3,
    CFG_Y_SCALE      = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_bin;
    logic [15:0]                   dropped_frames;
    logic signed [47:0]            x_coord;
    logic [15:0]                   y_coord;
  } in_item_t;

  typedef struct packed {
    kind_t                         kind;
    logic signed [SAMPLE_BITS-1:0] value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ABS,
    S_RD_MUL_LO,
    S_RD_MUL_HI,
    S_RD_BIN,
    S_RD_MEM,
    S_CLEAR,
    S_COPY,
    S_DRAIN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic push;
    logic line_reject;
    logic read_start;
    logic rd_abs;
    logic mul_lo;
    logic mul_hi;
    logic rd_bin;
    logic rd_mem;
    logic clr_start;
    logic clr_step;
    logic commit_adv;
    logic copy_step;
    logic commit_done;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t in_cmd;
    logic in_last;
    logic line_match;
    logic drop_zero;
    logic copy_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/waterfall_line_history_store.sv @@
// Top level of the waterfall line history store.
// Joins wlhs_ctrl and wlhs_datapath; types from wlhs_pkg.
//
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------------
//  input   | in_valid, in_stall, in_data    | push one bin or read one point
//  output  | out_valid, out_stall, out_data | read data, line accepted/rejected
//  config  | cfg_we, cfg_index, cfg_wdata   | one register write per cycle
//
// Push without last bin: taken in idle. Rejected line end: via the result state.
// Read: abs, low and high multiply, bin and memory states, set by two passes of
// the shared 32x32 multiplier and the registered line memory read. Commit:
// clears a row valid bit per cycle per dropped row, copies one bin per cycle.
// Reset: synchronous, no memory sweep; a per-row high-water mark makes unwritten
// bins read as zero. One result beat is held while out_stall is high.
module waterfall_line_history_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wlhs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wlhs_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [wlhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlhs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wlhs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  wlhs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  wlhs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

@@ src/wlhs_ctrl.sv @@
// Controller for the waterfall line history store: sequences reads,
// row clearing, line copy and result hand-off. Uses wlhs_pkg.
module wlhs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wlhs_pkg::dp_status_t st,
  output wlhs_pkg::dp_cmd_t    cmd
);
  import wlhs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (st.in_cmd == CMD_READ) begin
            state_nxt = S_RD_ABS;
          end else if (st.in_last) begin
            state_nxt = st.line_match ? S_CLEAR : S_RESULT;
          end
        end
      end
      S_RD_ABS:    state_nxt = S_RD_MUL_LO;
      S_RD_MUL_LO: state_nxt = S_RD_MUL_HI;
      S_RD_MUL_HI: state_nxt = S_RD_BIN;
      S_RD_BIN:    state_nxt = S_RD_MEM;
      S_RD_MEM:    state_nxt = S_RESULT;
      S_CLEAR: begin
        if (st.drop_zero) begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        if (st.copy_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:     state_nxt = S_RESULT;
      S_RESULT: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (st.in_cmd == CMD_READ) begin
            cmd.read_start = 1'b1;
          end else begin
            cmd.push = 1'b1;
            if (st.in_last) begin
              if (st.line_match) begin
                cmd.clr_start = 1'b1;
              end else begin
                cmd.line_reject = 1'b1;
              end
            end
          end
        end
      end
      S_RD_ABS:    cmd.rd_abs = 1'b1;
      S_RD_MUL_LO: cmd.mul_lo = 1'b1;
      S_RD_MUL_HI: cmd.mul_hi = 1'b1;
      S_RD_BIN:    cmd.rd_bin = 1'b1;
      S_RD_MEM:    cmd.rd_mem = 1'b1;
      S_CLEAR: begin
        if (st.drop_zero) begin
          cmd.commit_adv = 1'b1;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      S_COPY:      cmd.copy_step = 1'b1;
      S_DRAIN:     cmd.commit_done = 1'b1;
      S_RESULT:    cmd.load_out = st.out_free;
      default:     cmd = '0;
    endcase
  end

  a_copy_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY && st.copy_last) |=> (state_r == S_DRAIN))
    else $error("copy did not end in drain");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd_abs, cmd.mul_lo, cmd.mul_hi, cmd.rd_bin, cmd.rd_mem,
              cmd.clr_step, cmd.copy_step, cmd.commit_done}))
    else $error("more than one datapath step at once");

endmodule

@@ src/wlhs_datapath.sv @@
// Datapath for the waterfall line history store: config registers, staging
// and line memories, read coordinate mapping, output register. Uses wlhs_pkg.
module wlhs_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wlhs_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wlhs_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [wlhs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wlhs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wlhs_pkg::dp_cmd_t                   cmd,
  output wlhs_pkg::dp_status_t                st
);
  import wlhs_pkg::*;

  localparam int YP_W = (ROW_W + 24 > 32) ? ROW_W + 24 : 32;

  // configuration
  logic [10:0]        bins_r;
  logic [8:0]         lines_r;
  logic signed [47:0] xorg_r;
  logic [31:0]        xscale_r;
  logic [15:0]        yscale_r;

  logic [CNT_W-1:0]   eff_bins;
  logic [ROW_W-1:0]   lm1;

  // push / commit
  logic [SAMPLE_BITS-1:0] staging [MAX_BINS];
  logic [SAMPLE_BITS-1:0] line_store [MAX_BINS * MAX_LINES];
  logic [CNT_W-1:0]       wm_mem [MAX_LINES];

  logic [CNT_W-1:0]       bin_count_r, count_inc;
  logic [ROW_W-1:0]       newest_r, newest_inc;
  logic [ROW_W-1:0]       drop_r, drop_nxt;
  logic                   row_valid_r [MAX_LINES];
  logic                   wm_vld_r [MAX_LINES];
  logic [CNT_W-1:0]       wm_rd_r, wm_new;
  logic                   wmv_rd_r;
  logic [ROW_W-1:0]       wm_addr;
  logic [BIN_W-1:0]       cp_idx_r, cp_bin_r;
  logic                   cp_wen_r;
  logic [SAMPLE_BITS-1:0] stg_rd_r;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;

  // read mapping
  logic [48:0]        d_r, d_nxt;
  logic [31:0]        prod_r, prod_nxt;
  logic [48:0]        m_r;
  logic               neg_r;
  logic [YP_W-1:0]    top, prodx, ydiff;
  logic [ROW_W-1:0]   int_y, age, row_nxt, row_r;
  logic               y_oor_r;
  logic [31:0]        mul_a;
  logic [63:0]        mul_p;
  logic [63:0]        plo_r;
  logic [48:0]        phi_r;
  logic [32:0]        rnd;
  logic [49:0]        intx;
  logic               x_oor_r, x_oor_nxt;
  logic [BIN_W-1:0]   bin_r, bin_nxt;
  logic [SAMPLE_BITS-1:0] store_rd_r;
  logic               rv_rd_r;
  logic               hit;

  kind_t              pend_kind_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r   <= 11'd1024;
      lines_r  <= 9'd256;
      xorg_r   <= '0;
      xscale_r <= '0;
      yscale_r <= 16'd65280;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BINS_IN_USE:  bins_r   <= cfg_wdata[10:0];
        CFG_LINES_IN_USE: lines_r  <= cfg_wdata[8:0];
        CFG_X_ORIGIN:     xorg_r   <= cfg_wdata[47:0];
        CFG_X_SCALE:      xscale_r <= cfg_wdata[31:0];
        CFG_Y_SCALE:      yscale_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bins_r == '0) begin
      eff_bins = CNT_W'(1);
    end else if (32'(bins_r) > MAX_BINS) begin
      eff_bins = CNT_W'(MAX_BINS);
    end else begin
      eff_bins = CNT_W'(bins_r);
    end
    if (32'(lines_r) < 2) begin
      lm1 = ROW_W'(1);
    end else if (32'(lines_r) > MAX_LINES) begin
      lm1 = ROW_W'(MAX_LINES - 1);
    end else begin
      lm1 = ROW_W'(lines_r - 9'd1);
    end
  end

  // ---------------- push and commit ----------------
  assign count_inc  = (bin_count_r <= CNT_W'(MAX_BINS)) ? bin_count_r + CNT_W'(1)
                                                        : bin_count_r;
  assign newest_inc = (newest_r == ROW_W'(MAX_LINES - 1)) ? '0 : newest_r + ROW_W'(1);
  assign drop_nxt   = (32'(in_data.dropped_frames) > 32'(lm1)) ? lm1
                                                               : ROW_W'(in_data.dropped_frames);
  assign wm_new     = (wmv_rd_r && wm_rd_r > bin_count_r) ? wm_rd_r : bin_count_r;
  assign wm_addr    = cmd.commit_adv ? newest_inc : row_r;

  always_ff @(posedge clk) begin
    if (cmd.push && bin_count_r < CNT_W'(MAX_BINS)) begin
      staging[bin_count_r[BIN_W-1:0]] <= in_data.sample;
    end
    if (cmd.copy_step) begin
      stg_rd_r <= staging[cp_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= '0;
      newest_r    <= '0;
      drop_r      <= '0;
      cp_idx_r    <= '0;
      cp_wen_r    <= 1'b0;
      for (int i = 0; i < MAX_LINES; i++) begin
        row_valid_r[i] <= 1'b0;
        wm_vld_r[i]    <= 1'b0;
      end
    end else begin
      if (cmd.line_reject || cmd.commit_done) begin
        bin_count_r <= '0;
      end else if (cmd.push) begin
        bin_count_r <= count_inc;
      end
      if (cmd.clr_start) begin
        drop_r <= drop_nxt;
      end else if (cmd.clr_step) begin
        drop_r <= drop_r - ROW_W'(1);
      end
      if (cmd.clr_step || cmd.commit_adv) begin
        newest_r <= newest_inc;
      end
      if (cmd.clr_step) begin
        row_valid_r[newest_inc] <= 1'b0;
      end
      if (cmd.commit_done) begin
        row_valid_r[newest_r] <= 1'b1;
        wm_vld_r[newest_r]    <= 1'b1;
      end
      if (cmd.commit_adv) begin
        cp_idx_r <= '0;
      end else if (cmd.copy_step) begin
        cp_idx_r <= cp_idx_r + BIN_W'(1);
      end
      cp_wen_r <= cmd.copy_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_step) begin
      cp_bin_r <= cp_idx_r;
    end
  end

  // per-row high-water mark: bins at or beyond it were never written
  always_ff @(posedge clk) begin
    if (cmd.commit_done) begin
      wm_mem[newest_r] <= wm_new;
    end
    if (cmd.commit_adv || cmd.rd_mem) begin
      wm_rd_r  <= wm_mem[wm_addr];
      wmv_rd_r <= wm_vld_r[wm_addr];
    end
  end

  assign wr_addr = ADDR_W'(ADDR_W'(newest_r) * ADDR_W'(MAX_BINS)) + ADDR_W'(cp_bin_r);
  assign rd_addr = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(MAX_BINS)) + ADDR_W'(bin_r);

  always_ff @(posedge clk) begin
    if (cp_wen_r) begin
      line_store[wr_addr] <= stg_rd_r;
    end
    if (cmd.rd_mem) begin
      store_rd_r <= line_store[rd_addr];
    end
  end

  // ---------------- read mapping ----------------
  assign d_nxt    = {in_data.x_coord[47], in_data.x_coord} - {xorg_r[47], xorg_r};
  assign prod_nxt = in_data.y_coord * yscale_r;

  always_comb begin
    top   = YP_W'(lm1) << 24;
    prodx = YP_W'(prod_r);
    ydiff = top - prodx;
    int_y = ROW_W'(ydiff >> 24);
    age   = lm1 - int_y;
    if (newest_r >= age) begin
      row_nxt = newest_r - age;
    end else begin
      row_nxt = ROW_W'((ROW_W+1)'(newest_r) + (ROW_W+1)'(MAX_LINES) - (ROW_W+1)'(age));
    end
  end

  // one 32x32 multiplier, used for the low then the high half of |d|
  assign mul_a = cmd.mul_hi ? 32'(m_r[48:32]) : m_r[31:0];
  assign mul_p = mul_a * xscale_r;

  always_comb begin
    rnd  = 33'(({1'b0, plo_r} + 65'h0_8000_0000) >> 32);
    intx = 50'(phi_r) + 50'(rnd);
    if (neg_r) begin
      x_oor_nxt = (phi_r != '0) || (plo_r > 64'h0000_0000_8000_0000);
      bin_nxt   = '0;
    end else begin
      x_oor_nxt = (intx >= 50'(eff_bins));
      bin_nxt   = intx[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_start) begin
      d_r    <= d_nxt;
      prod_r <= prod_nxt;
    end
    if (cmd.rd_abs) begin
      neg_r   <= d_r[48];
      m_r     <= d_r[48] ? (~d_r + 49'd1) : d_r;
      y_oor_r <= (prodx > top);
      row_r   <= row_nxt;
    end
    if (cmd.mul_lo) begin
      plo_r <= mul_p;
    end
    if (cmd.mul_hi) begin
      phi_r <= mul_p[48:0];
    end
    if (cmd.rd_bin) begin
      x_oor_r <= x_oor_nxt;
      bin_r   <= bin_nxt;
    end
    if (cmd.rd_mem) begin
      rv_rd_r <= row_valid_r[row_r];
    end
  end

  // ---------------- result ----------------
  assign hit = !x_oor_r && !y_oor_r && rv_rd_r && (CNT_W'(bin_r) < wm_rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_kind_r <= KIND_READ;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.rd_mem) begin
        pend_kind_r <= KIND_READ;
      end else if (cmd.line_reject) begin
        pend_kind_r <= KIND_REJECT;
      end else if (cmd.commit_done) begin
        pend_kind_r <= KIND_ACCEPT;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.kind  <= pend_kind_r;
      out_data_r.value <= (pend_kind_r == KIND_READ && hit) ? store_rd_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign st.in_cmd     = in_data.cmd;
  assign st.in_last    = in_data.last_bin;
  assign st.line_match = (count_inc == eff_bins);
  assign st.drop_zero  = (drop_r == '0);
  assign st.copy_last  = (CNT_W'(cp_idx_r) == bin_count_r - CNT_W'(1));
  assign st.out_free   = !out_valid_r || !out_stall;

  a_copy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cp_wen_r |-> (bin_count_r != '0))
    else $error("line copy write with empty line");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    bin_count_r <= CNT_W'(MAX_BINS + 1))
    else $error("bin count past saturation");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a held beat");

endmodule

@@ dv/waterfall_line_history_store_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for waterfall_line_history_store: directed, limit, long-line,
// random and back-pressure tests against a behavioral line history predictor.
// Depends on wlhs_pkg and the waterfall_line_history_store RTL.
module waterfall_line_history_store_test;
  import wlhs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // long enough for the longest commit to finish
  localparam int SETTLE_CYCLES = MAX_LINES + MAX_BINS + 8;
  localparam longint DIR_ORIGIN = -1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  bit [15:0] history_mem [int];
  bit row_live [MAX_LINES];
  bit [15:0] stage_line [MAX_BINS];
  int head_row = 0;
  int stage_count = 0;
  logic [10:0] bins_reg = 11'd1024;
  logic [8:0] lines_reg = 9'd256;
  logic signed [47:0] org_reg = '0;
  logic [31:0] xs_reg = '0;
  logic [15:0] ys_reg = 16'd65280;

  out_item_t pending_results [$];
  int mismatches = 0;
  int beats_sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int hold_cycles = 0;
  int cycle_count = 0;

  waterfall_line_history_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[waterfall_line_history_store] ERROR");
      $finish;
    end
  end

  function automatic int bins_eff();
    if (bins_reg == 0) return 1;
    if (bins_reg > MAX_BINS) return MAX_BINS;
    return int'(bins_reg);
  endfunction

  function automatic int lines_eff();
    if (lines_reg < 2) return 2;
    if (lines_reg > MAX_LINES) return MAX_LINES;
    return int'(lines_reg);
  endfunction

  function automatic logic [15:0] read_sample(logic signed [47:0] xc, logic [15:0] yc);
    longint unsigned nl, top, prod, int_y, age, m, mh, ml, s, bin_x;
    longint d;
    int row, addr;
    nl = lines_eff();
    top = (nl - 1) << 24;
    prod = yc;
    prod = prod * ys_reg;
    if (prod > top) return '0;
    int_y = (top - prod) >> 24;
    age = (nl - 1) - int_y;
    s = xs_reg;
    d = longint'(xc) - longint'(org_reg);
    if (d < 0) begin
      m = -d;
      mh = m >> 32;
      ml = m & 64'hFFFF_FFFF;
      if (mh * s != 0 || ml * s > 64'h8000_0000) return '0;
      bin_x = 0;
    end else begin
      m = d;
      mh = m >> 32;
      ml = m & 64'hFFFF_FFFF;
      // round to nearest bin
      bin_x = mh * s + ((ml * s + 64'h8000_0000) >> 32);
    end
    if (bin_x >= longint'(bins_eff())) return '0;
    row = (head_row + MAX_LINES - int'(age)) % MAX_LINES;
    if (!row_live[row]) return '0;
    addr = row * MAX_BINS + int'(bin_x);
    return history_mem.exists(addr) ? history_mem[addr] : '0;
  endfunction

  function automatic void predict_beat(in_item_t item);
    out_item_t res;
    int drop;
    res.value = '0;
    if (item.cmd == CMD_READ) begin
      res.kind = KIND_READ;
      res.value = read_sample(item.x_coord, item.y_coord);
      pending_results.push_back(res);
      return;
    end
    if (stage_count < MAX_BINS) stage_line[stage_count] = item.sample;
    if (stage_count <= MAX_BINS) stage_count++;
    if (!item.last_bin) return;
    if (stage_count == bins_eff()) begin
      drop = item.dropped_frames;
      if (drop > lines_eff() - 1) drop = lines_eff() - 1;
      // skipped rows are advanced over and cleared
      repeat (drop) begin
        head_row = (head_row + 1) % MAX_LINES;
        row_live[head_row] = 1'b0;
      end
      head_row = (head_row + 1) % MAX_LINES;
      for (int i = 0; i < stage_count; i++)
        history_mem[head_row * MAX_BINS + i] = stage_line[i];
      row_live[head_row] = 1'b1;
      res.kind = KIND_ACCEPT;
    end else begin
      res.kind = KIND_REJECT;
    end
    stage_count = 0;
    pending_results.push_back(res);
  endfunction

  function automatic in_item_t make_push(logic [15:0] smp, logic last, logic [15:0] drop);
    in_item_t item;
    item.cmd = CMD_PUSH;
    item.sample = smp;
    item.last_bin = last;
    item.dropped_frames = last ? drop : 16'($urandom);
    item.x_coord = 48'({$urandom, $urandom});
    item.y_coord = 16'($urandom);
    return item;
  endfunction

  function automatic in_item_t make_read(logic [47:0] xv, logic [15:0] yv);
    in_item_t item;
    item.cmd = CMD_READ;
    item.sample = 16'($urandom);
    item.last_bin = 1'($urandom);
    item.dropped_frames = 16'($urandom);
    item.x_coord = xv;
    item.y_coord = yv;
    return item;
  endfunction

  // mostly aimed at bins just inside and outside the line, rows inside the history
  function automatic in_item_t random_read();
    longint span, xv;
    int b, ymax;
    if ($urandom_range(0, 9) == 0) return make_read(48'({$urandom, $urandom}), 16'($urandom));
    b = int'($urandom_range(0, bins_eff() + 1)) - 1;
    if (xs_reg == 0) begin
      xv = longint'(org_reg) + longint'($urandom_range(0, 2)) - 1;
    end else begin
      span = (64'd1 << 32) / xs_reg;
      xv = longint'(org_reg) + longint'(b) * span - span / 2
           + longint'($urandom_range(0, 32'(span - 1)));
    end
    ymax = lines_eff() * 256 + 255;
    if (ymax > 65535) ymax = 65535;
    return make_read(xv[47:0], 16'($urandom_range(0, ymax)));
  endfunction

  function automatic logic [15:0] random_drop();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return '0;
    if (pick < 95) return 16'($urandom_range(1, 3));
    return 16'($urandom);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %0d",
                                  out_data.kind, out_data.value));
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
        if (out_data.value !== want.value)
          report_mismatch($sformatf("value %0d, want %0d", out_data.value, want.value));
      end
    end
  end

  // result side stalls: random modes, plus long hold-offs on request
  initial begin
    int mode_left;
    int stall_pct;
    mode_left = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 25;
            3: stall_pct = 50;
            default: stall_pct = 90;
          endcase
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_beat(in_item_t item);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    predict_beat(item);
  endtask

  task automatic push_line(int nbins, logic [15:0] drop);
    for (int i = 0; i < nbins; i++)
      send_beat(make_push(16'($urandom), i == nbins - 1, drop));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_BINS_IN_USE:  bins_reg = val[10:0];
      CFG_LINES_IN_USE: lines_reg = val[8:0];
      CFG_X_ORIGIN:     org_reg = val[47:0];
      CFG_X_SCALE:      xs_reg = val[31:0];
      CFG_Y_SCALE:      ys_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [10:0] b, logic [8:0] l, logic [47:0] o,
                            logic [31:0] xs, logic [15:0] ys);
    wait_idle();
    write_reg(CFG_BINS_IN_USE, b);
    write_reg(CFG_LINES_IN_USE, l);
    write_reg(CFG_X_ORIGIN, o);
    write_reg(CFG_X_SCALE, xs);
    write_reg(CFG_Y_SCALE, ys);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    set_config(11'd4, 9'd4, DIR_ORIGIN, 32'hFFFF_FFFF, 16'd49152);
    send_beat(make_read(DIR_ORIGIN, 16'd0));            // no line committed yet
    send_beat(make_push(16'h7FFF, 1'b0, 16'd0));
    send_beat(make_push(16'h8000, 1'b0, 16'd0));
    send_beat(make_push(16'h0000, 1'b0, 16'd0));
    send_beat(make_push(16'hFFFF, 1'b1, 16'd0));
    push_line(2, 16'd0);                                // short line
    for (int b = -1; b <= 4; b++)
      send_beat(make_read(DIR_ORIGIN + b, 16'd0));
    push_line(4, 16'hFFFF);                             // drop count clamps to lines-1
    send_beat(make_read(DIR_ORIGIN + 1, 16'd256));      // cleared row
    send_beat(make_read(DIR_ORIGIN + 2, 16'hFFFF));     // above the history
    send_beat(make_read(48'h7FFF_FFFF_FFFF, 16'd0));
    send_beat(make_read(48'h8000_0000_0000, 16'd0));
  endtask

  task automatic test_register_limits();
    set_config(11'd0, 9'd1, 48'h7FFF_FFFF_FFFF, 32'd0, 16'd0);
    push_line(1, 16'd0);
    push_line(1, 16'd5);
    push_line(2, 16'd0);
    send_beat(make_read(48'h8000_0000_0000, 16'hFFFF));
    send_beat(make_read(48'h7FFF_FFFF_FFFF, 16'd0));
    send_beat(make_read(48'd0, 16'd300));
    set_config(11'd0, 9'd0, 48'h8000_0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
    push_line(1, 16'd0);
    send_beat(make_read(48'h8000_0000_0000, 16'hFFFF));
    send_beat(make_read(48'h8000_0000_0000, 16'd256));
    send_beat(make_read(48'h8000_0000_0000, 16'd0));
    send_beat(make_read(48'h8000_0000_0001, 16'd0));
    // unused register indexes must leave everything as is
    wait_idle();
    for (int i = int'(CFG_Y_SCALE) + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'({$urandom, $urandom}));
    @(negedge clk);
    cfg_we <= 1'b0;
    send_beat(make_read(48'h8000_0000_0000, 16'd0));
    set_config(11'd2, 9'h1FF, 48'd0, 32'h8000_0000, 16'd65280);
    push_line(2, 16'd0);
    for (int b = 0; b < 6; b++)
      send_beat(make_read(48'(b), 16'd0));
  endtask

  task automatic test_long_lines();
    set_config(11'h7FF, 9'h1FF, 48'd0, 32'hFFFF_FFFF, 16'd65280);
    push_line(MAX_BINS, 16'd0);
    push_line(MAX_BINS + 2, 16'd0);                     // overfull, count saturates
    send_beat(make_read(48'd0, 16'd0));
    send_beat(make_read(48'd1023, 16'd0));
    send_beat(make_read(48'd1024, 16'd0));
    set_config(11'd3, 9'h1FF, 48'd0, 32'hFFFF_FFFF, 16'd65280);
    send_beat(make_read(48'd500, 16'd0));
    push_line(3, 16'd0);
    send_beat(make_read(48'd2, 16'd0));
    // wider reads over a narrow newest line and a wide older one
    set_config(11'd1024, 9'h1FF, 48'd0, 32'hFFFF_FFFF, 16'd65280);
    send_beat(make_read(48'd500, 16'd0));
    send_beat(make_read(48'd500, 16'd256));
    send_beat(make_read(48'd1023, 16'd256));
  endtask

  task automatic test_random();
    int quota_end, pick, nb, nl, alt;
    logic [47:0] org;
    logic [31:0] xs;
    logic [15:0] ys;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 5))
        0: nb = 1;
        1: nb = 2;
        2: nb = 33;
        default: nb = $urandom_range(3, 16);
      endcase
      case ($urandom_range(0, 5))
        0: nl = 2;
        1: nl = 256;
        2: nl = 0;
        3: nl = 511;
        default: nl = $urandom_range(3, 16);
      endcase
      pick = $urandom_range(0, 3);
      org = (pick < 2) ? 48'(int'($urandom_range(0, 2000)) - 1000) : 48'({$urandom, $urandom});
      case ($urandom_range(0, 4))
        0: xs = '0;
        1: xs = 32'hFFFF_FFFF;
        2: xs = 32'h8000_0000;
        default: xs = $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
      endcase
      alt = (nl < 2) ? 2 : (nl > MAX_LINES) ? MAX_LINES : nl;
      ys = ($urandom_range(0, 4) != 0) ? 16'(((alt - 1) << 16) / alt) : 16'($urandom);
      set_config(11'(nb), 9'(nl), org, xs, ys);
      gaps_on = ($urandom_range(0, 2) != 0);
      quota_end = beats_sent + 85;
      while (beats_sent < quota_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_beat(random_read());
        end else if (pick < 85) begin
          push_line(bins_eff(), random_drop());
        end else if (pick < 95) begin
          alt = $urandom_range(1, bins_eff() + 3);
          if (alt == bins_eff()) alt++;
          push_line(alt, random_drop());
        end else begin
          // stray bin, spoils the next line
          send_beat(make_push(16'($urandom), 1'b0, 16'd0));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_config(11'd4, 9'd8, 48'd0, 32'hFFFF_FFFF, 16'd57344);
    gaps_on = 1'b0;
    repeat (3) push_line(4, 16'd0);
    // receiver holds off while reads keep coming, so the input stalls
    hold_cycles = 300;
    repeat (40) send_beat(random_read());
    wait_idle();
    gaps_on = 1'b1;
    repeat (10) begin
      push_line(4, random_drop());
      send_beat(random_read());
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_limits();
    test_long_lines();
    test_random();
    test_backpressure();
    wait_idle();
    if (mismatches == 0)
      $display("[waterfall_line_history_store] OK");
    else
      $display("[waterfall_line_history_store] ERROR");
    $finish;
  end

endmodule
